[sv/nmx_pkg.sv]
`timescale 1ns / 1ps

package nmx_pkg;

    localparam int NUM_TUBES_DEF = 6;
    localparam int TUBE_W        = 3;
    localparam int SYM_W         = 4;
    localparam int LED_W         = 8;
    localparam int FRAME_W       = 24;
    localparam int OUT_DEPTH     = 3;
    localparam int OUT_PTR_W     = 2;
    localparam int OUT_DATA_W    = FRAME_W + TUBE_W;

    localparam logic [LED_W-1:0] LED_FORCE_BIT = 8'h80;
    localparam logic [SYM_W-1:0] BLANK_SYMBOL  = 4'hF;
    localparam logic [SYM_W-1:0] DOT_SYMBOL    = 4'd10;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_TICK  = 1'b1
    } opcode_t;

    typedef struct packed {
        logic                 en;
        logic [TUBE_W-1:0]    addr;
        logic [FRAME_W-1:0]   data;
    } wr_req_t;

    // cathode pattern of a symbol as {high byte, low byte}
    function automatic logic [15:0] cathode_pattern(input logic [SYM_W-1:0] sym);
        logic [15:0] pat;
        unique case (sym)
            4'd0:    pat = 16'h124D;
            4'd1:    pat = 16'h9249;
            4'd2:    pat = 16'h5249;
            4'd3:    pat = 16'h3249;
            4'd4:    pat = 16'h1A49;
            4'd5:    pat = 16'h1649;
            4'd6:    pat = 16'h1349;
            4'd7:    pat = 16'h12C9;
            4'd8:    pat = 16'h1269;
            4'd9:    pat = 16'h1259;
            4'd10:   pat = 16'h124B;
            default: pat = 16'h1249;
        endcase
        return pat;
    endfunction

    // anode-select mask of a tube as {byte2, byte1, byte0}
    function automatic logic [FRAME_W-1:0] anode_mask(input logic [TUBE_W-1:0] tube);
        logic [FRAME_W-1:0] mask;
        unique case (tube)
            3'd0:    mask = 24'hEFFFFF;
            3'd1:    mask = 24'hFDFFFF;
            3'd2:    mask = 24'hFFBFFF;
            3'd3:    mask = 24'hFFF7FF;
            3'd4:    mask = 24'hFFFEFF;
            3'd5:    mask = 24'hFFFF7F;
            default: mask = 24'hFFFFFF;
        endcase
        return mask;
    endfunction

endpackage

[sv/nmx_word_encoder.sv]
`timescale 1ns / 1ps

module nmx_word_encoder #(
    parameter int NUM_TUBES = nmx_pkg::NUM_TUBES_DEF
) (
    input  logic                        wr_en,
    input  logic [nmx_pkg::TUBE_W-1:0]  tube,
    input  logic [nmx_pkg::SYM_W-1:0]   symbol,
    input  logic                        dot_off,
    input  logic [nmx_pkg::LED_W-1:0]   led_bits,
    input  logic                        mute,
    output nmx_pkg::wr_req_t            wr_req
);
    import nmx_pkg::*;

    logic [SYM_W-1:0]   sym_eff;
    logic               dot_lit;
    logic [15:0]        cat;
    logic [15:0]        dot_cat;
    logic [7:0]         dot_pat;
    logic [FRAME_W-1:0] mask;
    logic [7:0]         b0, b1, b2;

    always_comb begin
        sym_eff = mute ? BLANK_SYMBOL : symbol;
        dot_lit = !mute && !dot_off;
        cat     = cathode_pattern(sym_eff);
        dot_cat = cathode_pattern(DOT_SYMBOL);
        dot_pat = dot_lit ? dot_cat[7:0] : 8'h00;
        mask    = anode_mask(tube);
        b0      = (LED_FORCE_BIT | led_bits) & mask[7:0];
        b1      = (cat[7:0] | dot_pat) & mask[15:8];
        b2      = cat[15:8] & mask[23:16];
        // writes to a tube past the end are dropped
        wr_req.en   = wr_en && (tube < TUBE_W'(NUM_TUBES));
        wr_req.addr = tube;
        wr_req.data = {b2, b1, b0};
    end

endmodule

[sv/nmx_pattern_ram.sv]
`timescale 1ns / 1ps

module nmx_pattern_ram #(
    parameter int NUM_TUBES = nmx_pkg::NUM_TUBES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  nmx_pkg::wr_req_t             wr_req,
    input  logic                         rd_en,
    input  logic [nmx_pkg::TUBE_W-1:0]   rd_addr,
    output logic [nmx_pkg::FRAME_W-1:0]  rd_data
);
    import nmx_pkg::*;

    localparam int AW = (NUM_TUBES > 1) ? $clog2(NUM_TUBES) : 1;

    logic [FRAME_W-1:0] mem [NUM_TUBES];
    logic [NUM_TUBES-1:0] valid_reg;
    logic [FRAME_W-1:0] rd_data_reg;
    logic               rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_req.en) begin
            mem[wr_req.addr[AW-1:0]] <= wr_req.data;
        end
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr[AW-1:0]];
            rd_valid_reg <= valid_reg[rd_addr[AW-1:0]];
        end
    end

    // entries never written since reset read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_req.en) begin
            valid_reg[wr_req.addr[AW-1:0]] <= 1'b1;
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

[sv/nmx_out_fifo.sv]
`timescale 1ns / 1ps

module nmx_out_fifo (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           push,
    input  logic [nmx_pkg::OUT_DATA_W-1:0] push_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [nmx_pkg::OUT_DATA_W-1:0] out_data,
    output logic [nmx_pkg::OUT_PTR_W-1:0]  count
);
    import nmx_pkg::*;

    logic [OUT_DATA_W-1:0] buf_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [OUT_PTR_W-1:0]  cnt_reg, cnt_next;
    logic                  pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (cnt_reg != '0);
    assign out_data  = buf_reg[rd_ptr_reg];
    assign count     = cnt_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

[sv/nixie_mux_display_scanner_top.sv]
`timescale 1ns / 1ps

// channel  | dir | handshake         | payload
// ---------+-----+-------------------+---------------------------------------------
// s_       | in  | s_tvalid/s_tready | s_tdata[15:0] fields, s_tuser opcode
// m_       | out | m_tvalid/m_tready | m_tdata[31:0] frame_bits, scanned_tube
// cfg_     | in  | cfg_wr_en         | cfg_wr_data master_mute
//
// one word accepted per cycle while s_tready is high; a write lands in the pattern ram on the accept edge
// a tick reads the ram into its read register, and its frame is then pushed from there into a
// 3-deep output queue, which presents the frames on m_ in order
// s_tready drops when ticks in flight plus queued frames reach the queue depth
// reset: synchronous active low, clears scan index, mute, queue and entry valid bits

module nixie_mux_display_scanner_top #(
    parameter int NUM_TUBES = nmx_pkg::NUM_TUBES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // tube[2:0], symbol[6:3], dot_off[7], led_bits[15:8]
    input  logic        s_tuser,    // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // frame_bits[23:0], scanned_tube[26:24], zero[31:27]
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data
);
    import nmx_pkg::*;

    logic                  mute_reg;
    logic [TUBE_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                  st1_valid_reg;
    logic [TUBE_W-1:0]     st1_tube_reg;
    logic                  accept;
    logic                  tick_acc;
    logic                  write_acc;
    wr_req_t               wr_req;
    logic [FRAME_W-1:0]    rd_data;
    logic [OUT_DATA_W-1:0] q_data;
    logic [OUT_PTR_W-1:0]  q_count;
    logic [OUT_PTR_W:0]    occupancy;

    assign occupancy = {1'b0, q_count} + {{OUT_PTR_W{1'b0}}, st1_valid_reg};
    assign s_tready  = (occupancy < (OUT_PTR_W + 1)'(OUT_DEPTH));
    assign accept    = s_tvalid && s_tready;
    assign tick_acc  = accept && (opcode_t'(s_tuser) == OP_TICK);
    assign write_acc = accept && (opcode_t'(s_tuser) == OP_WRITE);

    always_comb begin
        scan_idx_next = scan_idx_reg;
        if (tick_acc) begin
            scan_idx_next = (scan_idx_reg == TUBE_W'(NUM_TUBES - 1)) ? '0
                                                                     : scan_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mute_reg      <= 1'b0;
            scan_idx_reg  <= '0;
            st1_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                mute_reg <= cfg_wr_data;
            end
            scan_idx_reg  <= scan_idx_next;
            st1_valid_reg <= tick_acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_acc) begin
            st1_tube_reg <= scan_idx_reg;
        end
    end

    nmx_word_encoder #(
        .NUM_TUBES (NUM_TUBES)
    ) u_encoder (
        .wr_en    (write_acc),
        .tube     (s_tdata[2:0]),
        .symbol   (s_tdata[6:3]),
        .dot_off  (s_tdata[7]),
        .led_bits (s_tdata[15:8]),
        .mute     (mute_reg),
        .wr_req   (wr_req)
    );

    nmx_pattern_ram #(
        .NUM_TUBES (NUM_TUBES)
    ) u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_req  (wr_req),
        .rd_en   (tick_acc),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_data)
    );

    nmx_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (st1_valid_reg),
        .push_data ({st1_tube_reg, rd_data}),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (q_data),
        .count     (q_count)
    );

    assign m_tdata = {{(32 - OUT_DATA_W){1'b0}}, q_data};

`ifndef SYNTH
    // scan index never leaves the tube range
    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_idx_reg < TUBE_W'(NUM_TUBES))
        else $error("scan index out of range");

    // a tick read always reaches the queue stage the next cycle
    a_tick_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && tick_acc) |=> st1_valid_reg)
        else $error("tick read lost");

    // nothing enters the queue stage without a tick
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && !tick_acc) |=> !st1_valid_reg)
        else $error("frame without tick");

    // flow control keeps queued plus in-flight frames within the queue depth
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        occupancy <= (OUT_PTR_W + 1)'(OUT_DEPTH))
        else $error("output queue overflow");

    // a ram write and a tick read never happen in the same cycle
    a_one_access: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr_req.en && tick_acc))
        else $error("ram write and read in one cycle");
`endif

endmodule

[test/tb_nixie_mux_display_scanner_top.sv]
`timescale 1ns / 1ps

module tb_nixie_mux_display_scanner_top;
    import nmx_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    // {high byte, low byte} per symbol, symbol 15 in the top slot
    localparam logic [16*16-1:0] CATHODE_LUT = {
        16'h1249, 16'h1249, 16'h1249, 16'h1249, 16'h1249, 16'h124B, 16'h1259, 16'h1269,
        16'h12C9, 16'h1349, 16'h1649, 16'h1A49, 16'h3249, 16'h5249, 16'h9249, 16'h124D
    };
    // {byte2, byte1, byte0} anode select per tube, tube 5 in the top slot
    localparam logic [6*24-1:0] ANODE_LUT = {
        24'hFFFF7F, 24'hFFFEFF, 24'hFFF7FF, 24'hFFBFFF, 24'hFDFFFF, 24'hEFFFFF
    };

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [TUBE_W-1:0]  tube;
    } scan_frame_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_data = 1'b0;

    scan_frame_t        pending_frames[$];
    scan_frame_t        oldest_frame;
    logic [FRAME_W-1:0] tube_words[NUM_TUBES_DEF];
    int                 scan_pos;
    logic               mute_model;
    int                 errors = 0;
    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    int                 hold_cycles = 0;
    int                 stall_cycles = 0;

    nixie_mux_display_scanner_top uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic void advance_display(opcode_t op, logic [2:0] tube, logic [3:0] sym,
                                            logic dot_off, logic [7:0] leds);
        logic [15:0] cath;
        logic [7:0]  dot;
        logic [3:0]  s;
        logic        d;
        scan_frame_t fr;
        if (op == OP_WRITE) begin
            if (tube >= NUM_TUBES_DEF)
                return;
            s = mute_model ? BLANK_SYMBOL : sym;
            d = mute_model ? 1'b1 : dot_off;
            cath = CATHODE_LUT[s*16 +: 16];
            dot = d ? 8'h00 : CATHODE_LUT[DOT_SYMBOL*16 +: 8];
            tube_words[tube] = {cath[15:8], cath[7:0] | dot, LED_FORCE_BIT | leds}
                               & ANODE_LUT[tube*24 +: 24];
        end else begin
            fr.frame = tube_words[scan_pos];
            fr.tube = scan_pos[2:0];
            pending_frames.push_back(fr);
            scan_pos = (scan_pos == NUM_TUBES_DEF - 1) ? 0 : scan_pos + 1;
        end
    endfunction

    task automatic send_word(opcode_t op, logic [2:0] tube, logic [3:0] sym, logic dot_off,
                             logic [7:0] leds);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {leds, dot_off, sym, tube};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        advance_display(op, tube, sym, dot_off, leds);
    endtask

    task automatic send_random_word();
        opcode_t    op;
        logic [2:0] tube;
        op = ($urandom_range(0, 99) < 40) ? OP_TICK : OP_WRITE;
        tube = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
        send_word(op, tube, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)));
    endtask

    // let every frame come back, then let a trailing write settle
    task automatic drain_display();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_mute(logic value);
        drain_display();
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        mute_model = value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_blank_after_reset();
        repeat (7)
            send_word(OP_TICK, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                      1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endtask

    task automatic test_each_tube_written();
        send_word(OP_WRITE, 3'd0, 4'd0,  1'b0, 8'h00);
        send_word(OP_WRITE, 3'd1, 4'd7,  1'b1, 8'h7F);
        send_word(OP_WRITE, 3'd2, 4'd10, 1'b0, 8'h80);
        send_word(OP_WRITE, 3'd3, 4'd9,  1'b0, 8'hAA);
        send_word(OP_WRITE, 3'd4, 4'd1,  1'b1, 8'h55);
        send_word(OP_WRITE, 3'd5, 4'd15, 1'b1, 8'hFF);
        // out of range tubes leave everything alone
        send_word(OP_WRITE, 3'd6, 4'd3,  1'b0, 8'h12);
        send_word(OP_WRITE, 3'd7, 4'd8,  1'b0, 8'hFF);
        repeat (6)
            send_word(OP_TICK, 3'd7, 4'd15, 1'b1, 8'hFF);
    endtask

    task automatic test_mute_blanks();
        set_mute(1'b1);
        send_word(OP_WRITE, 3'd3, 4'd4, 1'b0, 8'h01);
        repeat (3)
            send_word(OP_TICK, 3'd0, 4'd0, 1'b0, 8'h00);
        set_mute(1'b0);
    endtask

    task automatic test_random_phase(int n, int sender_pct, int receiver_pct, logic mute);
        set_mute(mute);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        repeat (n)
            send_random_word();
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = HOLD_CYCLES;
        repeat (40)
            send_word(($urandom_range(0, 3) == 0) ? OP_WRITE : OP_TICK,
                      3'($urandom_range(0, 5)), 4'($urandom_range(0, 15)),
                      1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endtask

    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_frames.size() == 0) begin
                $display("%0t: frame with nothing expected, actual %h", $time, m_tdata);
                errors++;
            end else begin
                oldest_frame = pending_frames.pop_front();
                if (m_tdata[23:0] !== oldest_frame.frame) begin
                    $display("%0t: frame_bits expected %h actual %h", $time,
                             oldest_frame.frame, m_tdata[23:0]);
                    errors++;
                end
                if (m_tdata[26:24] !== oldest_frame.tube) begin
                    $display("%0t: scanned_tube expected %0d actual %0d", $time,
                             oldest_frame.tube, m_tdata[26:24]);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        foreach (tube_words[i])
            tube_words[i] = '0;
        scan_pos = 0;
        mute_model = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_mute(1'b0);
        test_blank_after_reset();
        test_each_tube_written();
        test_mute_blanks();
        test_random_phase(370, 19, 67, 1'b0);
        test_random_phase(370, 67, 19, 1'b1);
        test_random_phase(300, 0, 0, 1'b0);
        test_output_backpressure();

        drain_display();
        repeat (8) @(posedge aclk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
